FILE: src/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// sdspi_pkg
// shared types, codes and the crc7 byte step for the sd spi command engine
// ----------------------------------------------------------------------------
package sdspi_pkg;

  // input opcodes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_RECEIVE = 1'b1;

  // response kinds
  localparam logic [2:0] RK_NONE    = 3'd0;
  localparam logic [2:0] RK_R1      = 3'd1;
  localparam logic [2:0] RK_R1_BUSY = 3'd2;
  localparam logic [2:0] RK_R3      = 3'd3;
  localparam logic [2:0] RK_R7      = 3'd4;
  localparam logic [2:0] RK_R2      = 3'd5;

  localparam logic [5:0] CMD_STOP      = 6'd12;
  localparam logic [1:0] CMD_START_BITS = 2'b01;
  localparam logic [7:0] BYTE_IDLE     = 8'hFF;
  localparam logic [7:0] FLAG_IDLE     = 8'h01;
  localparam logic [7:0] FLAG_ILLEGAL  = 8'h04;
  localparam logic [7:0] FLAG_MISC     = 8'h80;
  localparam logic [6:0] POLL_LAST     = 7'd127;
  localparam logic [1:0] PAYLOAD_LAST  = 2'd3;
  localparam logic [2:0] BEAT_CRC      = 3'd5;
  localparam logic [2:0] BEAT_FILLER   = 3'd6;
  localparam logic [6:0] CRC_POLY      = 7'h09;

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_RESP = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_ILLEGAL  = 2'd2,
    ST_INTERNAL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_POLL    = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_R2      = 2'd3
  } phase_e;

  // one classified job handed from front to back
  typedef struct packed {
    logic        is_cmd;
    logic [39:0] cmd_bytes;
    logic        crc_en;
    logic        filler;
    logic        resp_en;
    logic [7:0]  resp_byte;
    logic        done_en;
    status_e     status;
    logic        keep;
  } job_t;

  // one byte through the crc7 shift register, msb first
  function automatic logic [6:0] crc7_byte(input logic [7:0] data, input logic [6:0] crc);
    logic [7:0] c;
    logic [7:0] d;
    c = {1'b0, crc};
    d = data;
    for (int k = 0; k < 8; k++) begin
      c = {c[6:0], 1'b0};
      if (d[7] ^ c[7]) begin
        c = c ^ {1'b0, CRC_POLY};
      end
      d = {d[6:0], 1'b0};
    end
    return c[6:0];
  endfunction

endpackage

FILE: src/sdspi_fifo.sv
// ----------------------------------------------------------------------------
// sdspi_fifo
// small show-ahead job queue between the front and back parts
// ----------------------------------------------------------------------------
module sdspi_fifo #(
  parameter int Depth = 2,
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: src/sdspi_front.sv
// ----------------------------------------------------------------------------
// sdspi_front
// accepts input beats, tracks the command phase and classifies each beat
// into a job for the back part
// ----------------------------------------------------------------------------
module sdspi_front
  import sdspi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [5:0]  command_index_i,
  input  logic [31:0] argument_i,
  input  logic        crc_needed_i,
  input  logic [2:0]  response_kind_i,
  input  logic        data_follows_i,
  input  logic [7:0]  received_byte_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output job_t        job_o
);

  phase_e     phase_q, phase_d;
  logic [6:0] poll_q, poll_d;
  logic [2:0] kind_q, kind_d;
  logic       df_q, df_d;
  logic [1:0] pay_q, pay_d;
  logic [7:0] first_q, first_d;
  logic       accept;
  logic [7:0] r2_byte;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign r2_byte    = first_q | ((received_byte_i != '0) ? FLAG_MISC : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      poll_q  <= '0;
      kind_q  <= '0;
      df_q    <= 1'b0;
      pay_q   <= '0;
      first_q <= '0;
    end else begin
      phase_q <= phase_d;
      poll_q  <= poll_d;
      kind_q  <= kind_d;
      df_q    <= df_d;
      pay_q   <= pay_d;
      first_q <= first_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    poll_d  = poll_q;
    kind_d  = kind_q;
    df_d    = df_q;
    pay_d   = pay_q;
    first_d = first_q;
    job_o   = '0;
    push_o  = 1'b0;
    if (accept) begin
      if (opcode_i == OP_START) begin
        job_o.is_cmd    = 1'b1;
        job_o.cmd_bytes = {CMD_START_BITS, command_index_i, argument_i};
        job_o.crc_en    = crc_needed_i;
        job_o.filler    = (command_index_i == CMD_STOP);
        push_o  = 1'b1;
        kind_d  = response_kind_i;
        df_d    = data_follows_i;
        poll_d  = '0;
        pay_d   = '0;
        first_d = '0;
        phase_d = PH_POLL;
      end else begin
        case (phase_q)
          PH_POLL: begin
            if (received_byte_i == BYTE_IDLE) begin
              if (poll_q == POLL_LAST) begin
                poll_d        = '0;
                job_o.done_en = 1'b1;
                job_o.status  = ST_TIMEOUT;
                push_o        = 1'b1;
                phase_d       = PH_IDLE;
              end else begin
                poll_d = poll_q + 1'b1;
              end
            end else begin
              case (kind_q)
                RK_NONE: begin
                  job_o.done_en = 1'b1;
                  push_o        = 1'b1;
                  phase_d       = PH_IDLE;
                end
                RK_R1, RK_R1_BUSY: begin
                  job_o.resp_en   = 1'b1;
                  job_o.resp_byte = received_byte_i;
                  job_o.done_en   = 1'b1;
                  push_o          = 1'b1;
                  phase_d         = PH_IDLE;
                end
                RK_R3, RK_R7: begin
                  if ((received_byte_i & FLAG_ILLEGAL) != '0) begin
                    job_o.done_en = 1'b1;
                    job_o.status  = ST_ILLEGAL;
                    push_o        = 1'b1;
                    phase_d       = PH_IDLE;
                  end else if ((received_byte_i & ~FLAG_IDLE) != '0) begin
                    job_o.done_en = 1'b1;
                    job_o.status  = ST_INTERNAL;
                    push_o        = 1'b1;
                    phase_d       = PH_IDLE;
                  end else begin
                    pay_d   = '0;
                    phase_d = PH_PAYLOAD;
                  end
                end
                RK_R2: begin
                  first_d = received_byte_i;
                  phase_d = PH_R2;
                end
                default: begin
                  job_o.done_en = 1'b1;
                  job_o.status  = ST_INTERNAL;
                  push_o        = 1'b1;
                  phase_d       = PH_IDLE;
                end
              endcase
            end
          end
          PH_PAYLOAD: begin
            job_o.resp_en   = 1'b1;
            job_o.resp_byte = received_byte_i;
            push_o          = 1'b1;
            pay_d           = pay_q + 1'b1;
            if (pay_q == PAYLOAD_LAST) begin
              job_o.done_en = 1'b1;
              phase_d       = PH_IDLE;
            end
          end
          PH_R2: begin
            job_o.resp_en   = 1'b1;
            job_o.resp_byte = r2_byte;
            job_o.done_en   = 1'b1;
            job_o.status    = ((r2_byte & ~FLAG_IDLE) != '0) ? ST_INTERNAL : ST_OK;
            push_o          = 1'b1;
            phase_d         = PH_IDLE;
          end
          default: begin
            // receive while idle is dropped
          end
        endcase
      end
    end
    job_o.keep = job_o.done_en && (job_o.status == ST_OK) && df_q;
  end

endmodule

FILE: src/sdspi_back.sv
// ----------------------------------------------------------------------------
// sdspi_back
// expands queued jobs into result beats, one per cycle while not stalled, with crc7
// built byte by byte while the command goes out
// ----------------------------------------------------------------------------
module sdspi_back
  import sdspi_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] item_kind_o,
  output logic [7:0] byte_value_o,
  output logic [1:0] status_o,
  output logic       keep_selected_o,
  output logic       last_o
);

  job_t       job_q;
  logic       busy_q;
  logic [2:0] idx_q;
  logic [6:0] crc_q;
  logic       out_valid_q;
  kind_e      kind_q;
  logic [7:0] byte_q;
  status_e    status_q;
  logic       keep_q, last_q;

  logic       adv, issue;
  kind_e      beat_kind;
  logic [7:0] beat_byte;
  status_e    beat_status;
  logic       beat_keep, beat_last;
  logic [7:0] cmd_byte;

  assign adv   = !out_valid_q || out_ready_i;
  assign issue = busy_q && adv;
  assign pop_o = job_valid_i && (!busy_q || (issue && beat_last));

  always_comb begin
    case (idx_q)
      3'd0:    cmd_byte = job_q.cmd_bytes[39:32];
      3'd1:    cmd_byte = job_q.cmd_bytes[31:24];
      3'd2:    cmd_byte = job_q.cmd_bytes[23:16];
      3'd3:    cmd_byte = job_q.cmd_bytes[15:8];
      3'd4:    cmd_byte = job_q.cmd_bytes[7:0];
      BEAT_CRC: cmd_byte = {crc_q, 1'b1};
      default: cmd_byte = BYTE_IDLE;
    endcase
  end

  always_comb begin
    beat_kind   = KIND_TX;
    beat_byte   = cmd_byte;
    beat_status = ST_OK;
    beat_keep   = 1'b0;
    beat_last   = 1'b0;
    if (job_q.is_cmd) begin
      beat_last = ((idx_q == BEAT_CRC) && !job_q.filler) || (idx_q == BEAT_FILLER);
    end else if ((idx_q == '0) && job_q.resp_en) begin
      beat_kind = KIND_RESP;
      beat_byte = job_q.resp_byte;
      beat_last = !job_q.done_en;
    end else begin
      beat_kind   = KIND_DONE;
      beat_byte   = '0;
      beat_status = job_q.status;
      beat_keep   = job_q.keep;
      beat_last   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= busy_q;
      end
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
        crc_q  <= '0;
      end else if (issue) begin
        idx_q <= idx_q + 1'b1;
        if (beat_last) begin
          busy_q <= 1'b0;
        end
        if (job_q.is_cmd && job_q.crc_en && (idx_q < BEAT_CRC)) begin
          crc_q <= crc7_byte(cmd_byte, crc_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (issue) begin
      kind_q   <= beat_kind;
      byte_q   <= beat_byte;
      status_q <= beat_status;
      keep_q   <= beat_keep;
      last_q   <= beat_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign item_kind_o     = kind_q;
  assign byte_value_o    = byte_q;
  assign status_o        = status_q;
  assign keep_selected_o = keep_q;
  assign last_o          = last_q;

endmodule

FILE: src/sd_spi_command_engine.sv
// ----------------------------------------------------------------------------
// sd_spi_command_engine
// host side of the sd card spi-mode command phase: command framing with
// crc7, response polling, response checks and completion status
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------
//  in      | input     | in_valid_i / in_ready_o  | opcode, command, argument, byte
//  out     | output    | out_valid_o / out_ready_i| kind, byte, status, keep, last
//
// - the front takes one input beat per cycle while the job queue has room
// - the back sends one result beat per cycle while the output is not stalled;
//   a start beat makes six or seven transmit beats, a receive beat zero to two
// - the first result of an input beat passes the job queue and the output register
// - crc7 is folded in one byte per result beat as the command goes out
// - reset clears the phase, queue and output valid; no clearing pass
// - a stalled output holds its beat in the output register
//
module sd_spi_command_engine
  import sdspi_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [5:0]  command_index_i,
  input  logic [31:0] argument_i,
  input  logic        crc_needed_i,
  input  logic [2:0]  response_kind_i,
  input  logic        data_follows_i,
  input  logic [7:0]  received_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  item_kind_o,
  output logic [7:0]  byte_value_o,
  output logic [1:0]  status_o,
  output logic        keep_selected_o,
  output logic        last_o
);

  // job handoff between classification and beat generation
  job_t                 front_job;
  logic                 front_push;
  logic                 queue_full;
  logic                 queue_valid;
  logic                 queue_pop;
  logic [$bits(job_t)-1:0] queue_data;

  // front: phase tracking, poll count, response checks
  sdspi_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .opcode_i,
    .command_index_i,
    .argument_i,
    .crc_needed_i,
    .response_kind_i,
    .data_follows_i,
    .received_byte_i,
    .queue_full_i (queue_full),
    .push_o       (front_push),
    .job_o        (front_job)
  );

  // short queue so front and back stall independently
  sdspi_fifo #(
    .Depth (QueueDepth),
    .Width ($bits(job_t))
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (front_push),
    .data_i  (front_job),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .data_o  (queue_data)
  );

  // back: beat sequencing, crc7, output register
  sdspi_back u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i (queue_valid),
    .job_i       (job_t'(queue_data)),
    .pop_o       (queue_pop),
    .out_valid_o,
    .out_ready_i,
    .item_kind_o,
    .byte_value_o,
    .status_o,
    .keep_selected_o,
    .last_o
  );

endmodule

FILE: src/sdspi_checker.sv
// ----------------------------------------------------------------------------
// sdspi_checker
// port-level checks on the result channel of the command engine
// ----------------------------------------------------------------------------
module sdspi_checker
  import sdspi_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] item_kind_o,
  input logic [7:0] byte_value_o,
  input logic [1:0] status_o,
  input logic       keep_selected_o,
  input logic       last_o
);

  // stalled beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(byte_value_o) && $stable(last_o))
    else $error("result beat changed while stalled");

  // completion closes its input and carries no byte
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (item_kind_o == KIND_DONE) |-> last_o && (byte_value_o == '0))
    else $error("completion beat malformed");

  // status and keep only on completion
  a_side_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (item_kind_o != KIND_DONE) |-> (status_o == ST_OK) && !keep_selected_o)
    else $error("status or keep set on a byte beat");

  // last transmit byte is the crc byte or the filler, both end in a one
  a_tx_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (item_kind_o == KIND_TX) && last_o |-> byte_value_o[0])
    else $error("command tail byte lacks stop bit");

endmodule

bind sd_spi_command_engine sdspi_checker u_checker (.*);
